>>> rtl/core/rci_pkg.sv
package rci_pkg;

	localparam int CHANNELS = 4;
	localparam int CH_W     = $clog2(CHANNELS);

	localparam int CMD_W    = 12;
	localparam int DELTA_W  = 14;
	localparam int STEP_W   = 8;
	localparam int IV_W     = 16;
	localparam int PER_W    = 15;
	localparam int CFG_W    = 15;
	localparam int IDX_W    = 1;

	// product delta * steps, its magnitude, and the signed quotient
	localparam int PROD_W   = DELTA_W + STEP_W + 1;
	localparam int DIV_W    = DELTA_W + STEP_W - 1;
	localparam int QS_W     = DIV_W + 1;
	localparam int NOW_W    = QS_W + 1;
	localparam int DIFF_W   = NOW_W + 1;
	localparam int DVS_W    = PER_W;
	localparam int DCNT_W   = $clog2(DIV_W + 1);

	localparam int IV_MIN    = 1000;
	localparam int IV_MAX    = 20000;
	localparam int IV_ADD    = 1000;
	localparam int PER_MIN   = 125;
	localparam int PER_MAX   = 32000;
	localparam int PER_RESET = 1000;

	localparam int DELTA_MAX = 2 ** (DELTA_W - 1) - 1;
	localparam int DELTA_MIN = -(2 ** (DELTA_W - 1));
	localparam int CMD_MAX   = 2 ** (CMD_W - 1) - 1;
	localparam int CMD_MIN   = -(2 ** (CMD_W - 1));

	localparam logic [IDX_W-1:0] REG_SMOOTH = 1'd0;
	localparam logic [IDX_W-1:0] REG_PERIOD = 1'd1;

	typedef logic [4:0] pc_t;

	typedef enum logic [3:0] {
		U_NOP,
		U_LOAD,
		U_DIV_N,
		U_SET_N,
		U_DIV_OLD,
		U_UPD,
		U_SET_STEPS,
		U_DEC,
		U_CH_CLR,
		U_DIV_OUT,
		U_RES,
		U_PASS,
		U_EMIT
	} uop_t;

	typedef enum logic [3:0] {
		C_NONE,
		C_ALWAYS,
		C_NO_ACCEPT,
		C_SMOOTH_OFF,
		C_NO_FRAME,
		C_DIV_BUSY,
		C_MORE_CH,
		C_STEPS_ZERO,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		uop_t  op;
		cond_t cond;
		pc_t   target;
	} uword_t;

	typedef struct packed {
		logic no_accept;
		logic smooth_off;
		logic no_frame;
		logic div_busy;
		logic more_ch;
		logic steps_zero;
		logic out_busy;
	} status_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [DVS_W-1:0]  divisor;
	} div_req_t;

	// program addresses
	localparam pc_t PC_WAIT   = 5'd0;
	localparam pc_t PC_MODE   = 5'd1;
	localparam pc_t PC_FRAME  = 5'd2;
	localparam pc_t PC_DIVN   = 5'd3;
	localparam pc_t PC_DIVN_W = 5'd4;
	localparam pc_t PC_SETN   = 5'd5;
	localparam pc_t PC_OLD    = 5'd6;
	localparam pc_t PC_OLD_W  = 5'd7;
	localparam pc_t PC_UPD    = 5'd8;
	localparam pc_t PC_STEPS  = 5'd9;
	localparam pc_t PC_TICK   = 5'd10;
	localparam pc_t PC_RAMP   = 5'd11;
	localparam pc_t PC_OUTD   = 5'd12;
	localparam pc_t PC_OUTD_W = 5'd13;
	localparam pc_t PC_RES    = 5'd14;
	localparam pc_t PC_HOLD   = 5'd15;
	localparam pc_t PC_EMIT   = 5'd16;
	localparam pc_t PC_PASS   = 5'd17;

	function automatic uword_t uw(input uop_t op, input cond_t cond, input pc_t target);
		uword_t w;
		w.op     = op;
		w.cond   = cond;
		w.target = target;
		return w;
	endfunction

	// microprogram rom
	function automatic uword_t ucode(input pc_t pc);
		uword_t w;
		w = uw(U_NOP, C_ALWAYS, PC_WAIT);
		unique case (pc)
			PC_WAIT:   w = uw(U_LOAD,      C_NO_ACCEPT,  PC_WAIT);
			PC_MODE:   w = uw(U_NOP,       C_SMOOTH_OFF, PC_PASS);
			PC_FRAME:  w = uw(U_NOP,       C_NO_FRAME,   PC_TICK);
			PC_DIVN:   w = uw(U_DIV_N,     C_NONE,       PC_WAIT);
			PC_DIVN_W: w = uw(U_NOP,       C_DIV_BUSY,   PC_DIVN_W);
			PC_SETN:   w = uw(U_SET_N,     C_NONE,       PC_WAIT);
			PC_OLD:    w = uw(U_DIV_OLD,   C_NONE,       PC_WAIT);
			PC_OLD_W:  w = uw(U_NOP,       C_DIV_BUSY,   PC_OLD_W);
			PC_UPD:    w = uw(U_UPD,       C_MORE_CH,    PC_OLD);
			PC_STEPS:  w = uw(U_SET_STEPS, C_ALWAYS,     PC_RAMP);
			PC_TICK:   w = uw(U_DEC,       C_NONE,       PC_WAIT);
			PC_RAMP:   w = uw(U_CH_CLR,    C_STEPS_ZERO, PC_PASS);
			PC_OUTD:   w = uw(U_DIV_OUT,   C_NONE,       PC_WAIT);
			PC_OUTD_W: w = uw(U_NOP,       C_DIV_BUSY,   PC_OUTD_W);
			PC_RES:    w = uw(U_RES,       C_MORE_CH,    PC_OUTD);
			PC_HOLD:   w = uw(U_NOP,       C_OUT_BUSY,   PC_HOLD);
			PC_EMIT:   w = uw(U_EMIT,      C_ALWAYS,     PC_WAIT);
			PC_PASS:   w = uw(U_PASS,      C_ALWAYS,     PC_HOLD);
			default:   w = uw(U_NOP,       C_ALWAYS,     PC_WAIT);
		endcase
		return w;
	endfunction

	function automatic logic signed [DELTA_W-1:0] sat_delta(input logic signed [DIFF_W-1:0] v);
		logic signed [DELTA_W-1:0] r;
		if (v > DELTA_MAX) begin
			r = DELTA_W'(DELTA_MAX);
		end else if (v < DELTA_MIN) begin
			r = DELTA_W'(DELTA_MIN);
		end else begin
			r = DELTA_W'(v);
		end
		return r;
	endfunction

	function automatic logic signed [CMD_W-1:0] sat_cmd(input logic signed [NOW_W-1:0] v);
		logic signed [CMD_W-1:0] r;
		if (v > CMD_MAX) begin
			r = CMD_W'(CMD_MAX);
		end else if (v < CMD_MIN) begin
			r = CMD_W'(CMD_MIN);
		end else begin
			r = CMD_W'(v);
		end
		return r;
	endfunction

endpackage

>>> rtl/core/rci_if.sv
interface rci_in_if import rci_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     new_frame;
	logic [IV_W-1:0]          rx_interval_us;
	logic signed [CMD_W-1:0]  cmd_roll;
	logic signed [CMD_W-1:0]  cmd_pitch;
	logic signed [CMD_W-1:0]  cmd_yaw;
	logic signed [CMD_W-1:0]  cmd_throttle;

	modport source (
		output valid, new_frame, rx_interval_us, cmd_roll, cmd_pitch, cmd_yaw, cmd_throttle,
		input  ready
	);
	modport sink (
		input  valid, new_frame, rx_interval_us, cmd_roll, cmd_pitch, cmd_yaw, cmd_throttle,
		output ready
	);
endinterface

interface rci_out_if import rci_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [CMD_W-1:0]  out_roll;
	logic signed [CMD_W-1:0]  out_pitch;
	logic signed [CMD_W-1:0]  out_yaw;
	logic signed [CMD_W-1:0]  out_throttle;

	modport source (
		output valid, out_roll, out_pitch, out_yaw, out_throttle,
		input  ready
	);
	modport sink (
		input  valid, out_roll, out_pitch, out_yaw, out_throttle,
		output ready
	);
endinterface

>>> rtl/core/rci_divider.sv
module rci_divider import rci_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  div_req_t          req,
	output logic              busy,
	output logic [DIV_W-1:0]  quotient
);

	logic [DCNT_W-1:0] cnt_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DIV_W-1:0]  dq_q;
	logic [DVS_W:0]    trial;
	logic [DVS_W:0]    diff;
	logic              ge;

	// restoring division, one quotient bit per cycle
	always_comb begin
		trial = {rem_q, dq_q[DIV_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= DCNT_W'(DIV_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvs_q <= req.divisor;
			dq_q  <= req.dividend;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			dq_q  <= {dq_q[DIV_W-2:0], ge};
		end
	end

	assign busy     = cnt_q != '0;
	assign quotient = dq_q;

endmodule

>>> rtl/core/rci_sequencer.sv
module rci_sequencer import rci_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  status_t sts,
	output uword_t  uword
);

	pc_t  pc_q;
	pc_t  pc_next;
	logic jump;

	always_comb begin
		uword = ucode(pc_q);
		unique case (uword.cond)
			C_NONE:       jump = 1'b0;
			C_ALWAYS:     jump = 1'b1;
			C_NO_ACCEPT:  jump = sts.no_accept;
			C_SMOOTH_OFF: jump = sts.smooth_off;
			C_NO_FRAME:   jump = sts.no_frame;
			C_DIV_BUSY:   jump = sts.div_busy;
			C_MORE_CH:    jump = sts.more_ch;
			C_STEPS_ZERO: jump = sts.steps_zero;
			C_OUT_BUSY:   jump = sts.out_busy;
			default:      jump = 1'b1;
		endcase
		pc_next = jump ? uword.target : pc_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_WAIT;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

>>> rtl/core/rc_command_interpolator.sv
// channel   role      fields
// sticks    sink      new_frame, rx_interval_us, cmd_roll, cmd_pitch, cmd_yaw, cmd_throttle
// ramped    source    out_roll, out_pitch, out_yaw, out_throttle
// cfg_*     write     cfg_we, cfg_index (0 smoothing_enable, 1 loop_period_us), cfg_wdata
//
// one transaction at a time, run by an 18-step microprogram; each division on the shared
// serial divider: start, a bit step per quotient bit, exit, the step that uses the quotient
// new-frame tick with an active ramp: 1 + 2*CHANNELS divisions
// ramp tick: CHANNELS divisions; pass-through and a finished-ramp tick need no division
// the result sits in an output register; the next transaction is taken while it waits, and
// the program holds before emit until it drains; arst_n clears all but datapath registers
module rc_command_interpolator import rci_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_wdata,
	rci_in_if.sink            sticks,
	rci_out_if.source         ramped
);

	// configuration
	logic              enable_q;
	logic [PER_W-1:0]  period_q;

	// ramp state
	logic signed [CMD_W-1:0]    last_q  [CHANNELS];
	logic signed [DELTA_W-1:0]  delta_q [CHANNELS];
	logic [STEP_W-1:0]          steps_left_q;
	logic [STEP_W-1:0]          steps_total_q;

	// working registers for the current transaction
	logic signed [CMD_W-1:0]  cmd_q [CHANNELS];
	logic signed [CMD_W-1:0]  res_q [CHANNELS];
	logic                     new_frame_q;
	logic [IV_W-1:0]          iv_q;
	logic [STEP_W-1:0]        n_q;
	logic                     neg_q;
	logic [CH_W-1:0]          ch_q;

	// output register
	logic                     out_valid_q;
	logic signed [CMD_W-1:0]  out_q [CHANNELS];

	uword_t            uword;
	status_t           sts;
	div_req_t          div_req;
	logic              div_busy;
	logic [DIV_W-1:0]  quotient;

	logic                       accept;
	logic [IV_W-1:0]            iv_c;
	logic [PER_W-1:0]           per_c;
	logic [STEP_W-1:0]          tot_nz;
	logic signed [PROD_W-1:0]   prod_v;
	logic [PROD_W-1:0]          mag_v;
	logic signed [QS_W-1:0]     qs_v;
	logic signed [NOW_W-1:0]    now_v;
	logic signed [DIFF_W-1:0]   diff_v;

	rci_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.uword  (uword)
	);

	rci_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.busy     (div_busy),
		.quotient (quotient)
	);

	// input is taken only in the wait step of the program
	assign sticks.ready = uword.op == U_LOAD;
	assign accept       = sticks.valid & sticks.ready;

	always_comb begin
		sts.no_accept  = !sticks.valid;
		sts.smooth_off = !enable_q;
		sts.no_frame   = !new_frame_q;
		sts.div_busy   = div_busy;
		sts.more_ch    = ch_q != CH_W'(CHANNELS - 1);
		sts.steps_zero = steps_left_q == '0;
		sts.out_busy   = out_valid_q & !ramped.ready;
	end

	// datapath arithmetic
	always_comb begin
		// clamped receiver interval and loop period
		if (iv_q < IV_MIN) begin
			iv_c = IV_W'(IV_MIN);
		end else if (iv_q > IV_MAX) begin
			iv_c = IV_W'(IV_MAX);
		end else begin
			iv_c = iv_q;
		end
		if (period_q < PER_MIN) begin
			per_c = PER_W'(PER_MIN);
		end else if (period_q > PER_MAX) begin
			per_c = PER_W'(PER_MAX);
		end else begin
			per_c = period_q;
		end
		tot_nz = (steps_total_q == '0) ? STEP_W'(1) : steps_total_q;

		// delta * steps_left, split into sign and magnitude for the divider
		prod_v = PROD_W'(delta_q[ch_q]) * PROD_W'($signed({1'b0, steps_left_q}));
		mag_v  = prod_v[PROD_W-1] ? PROD_W'(-prod_v) : PROD_W'(prod_v);

		// quotient back to signed, truncated toward zero
		qs_v   = neg_q ? -QS_W'($signed({1'b0, quotient})) : QS_W'($signed({1'b0, quotient}));
		now_v  = NOW_W'(last_q[ch_q]) - NOW_W'(qs_v);
		diff_v = DIFF_W'(cmd_q[ch_q]) - DIFF_W'(now_v);

		div_req.start    = (uword.op == U_DIV_N) || (uword.op == U_DIV_OLD)
			|| (uword.op == U_DIV_OUT);
		div_req.dividend = (uword.op == U_DIV_N)
			? DIV_W'(iv_c) + DIV_W'(IV_ADD) : mag_v[DIV_W-1:0];
		if (uword.op == U_DIV_N) begin
			div_req.divisor = per_c;
		end else if (uword.op == U_DIV_OLD) begin
			div_req.divisor = DVS_W'(n_q);
		end else begin
			div_req.divisor = DVS_W'(tot_nz);
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			period_q <= PER_W'(PER_RESET);
		end else if (cfg_we) begin
			if (cfg_index == REG_SMOOTH) begin
				enable_q <= cfg_wdata[0];
			end
			if (cfg_index == REG_PERIOD) begin
				period_q <= cfg_wdata[PER_W-1:0];
			end
		end
	end

	// ramp state, channel counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				last_q[c]  <= '0;
				delta_q[c] <= '0;
			end
			steps_left_q  <= '0;
			steps_total_q <= '0;
			ch_q          <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (out_valid_q && ramped.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (uword.op)
				U_SET_N, U_CH_CLR: begin
					ch_q <= '0;
				end
				U_UPD: begin
					// new ramp starts from where the old one stands now
					delta_q[ch_q] <= sat_delta(diff_v);
					last_q[ch_q]  <= cmd_q[ch_q];
					ch_q          <= ch_q + 1'b1;
				end
				U_SET_STEPS: begin
					steps_total_q <= n_q;
					steps_left_q  <= (n_q == '0) ? '0 : n_q - 1'b1;
				end
				U_DEC: begin
					if (steps_left_q != '0) begin
						steps_left_q <= steps_left_q - 1'b1;
					end
				end
				U_RES: begin
					ch_q <= ch_q + 1'b1;
				end
				U_EMIT: begin
					out_valid_q <= 1'b1;
				end
				U_NOP, U_LOAD, U_DIV_N, U_DIV_OLD, U_DIV_OUT, U_PASS: begin
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			new_frame_q <= sticks.new_frame;
			iv_q        <= sticks.rx_interval_us;
			cmd_q[0]    <= sticks.cmd_roll;
			cmd_q[1]    <= sticks.cmd_pitch;
			cmd_q[2]    <= sticks.cmd_yaw;
			cmd_q[3]    <= sticks.cmd_throttle;
		end
		if (uword.op == U_SET_N) begin
			n_q <= quotient[STEP_W-1:0] + 1'b1;
		end
		if ((uword.op == U_DIV_OLD) || (uword.op == U_DIV_OUT)) begin
			neg_q <= prod_v[PROD_W-1];
		end
		if (uword.op == U_RES) begin
			res_q[ch_q] <= sat_cmd(now_v);
		end
		if (uword.op == U_PASS) begin
			for (int c = 0; c < CHANNELS; c++) begin
				res_q[c] <= cmd_q[c];
			end
		end
		if (uword.op == U_EMIT) begin
			for (int c = 0; c < CHANNELS; c++) begin
				out_q[c] <= res_q[c];
			end
		end
	end

	assign ramped.valid        = out_valid_q;
	assign ramped.out_roll     = out_q[0];
	assign ramped.out_pitch    = out_q[1];
	assign ramped.out_yaw      = out_q[2];
	assign ramped.out_throttle = out_q[3];

	// a ramp never has more steps left than its length
	assert property (@(posedge clk) disable iff (!arst_n)
		(steps_left_q == '0) || (steps_left_q < steps_total_q))
		else $error("steps_left not below steps_total");

	// a division is only started on an idle divider
	assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_busy)
		else $error("division started while divider busy");

	// no new transaction is taken while a division runs
	assert property (@(posedge clk) disable iff (!arst_n)
		sticks.ready |-> !div_busy)
		else $error("input ready during division");

	// the emit step always presents a result on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(uword.op == U_EMIT) |=> ramped.valid)
		else $error("emit without output valid");

endmodule

>>> tb/sv/rc_command_interpolator_tb.sv
module rc_command_interpolator_tb;
	import rci_pkg::*;

	// one tick in, one set of four commands out
	typedef logic [CHANNELS-1:0][CMD_W-1:0] cmds_t;  // [0] roll .. [3] throttle

	typedef struct packed {
		logic             new_frame;
		logic [IV_W-1:0]  interval;
		cmds_t            cmd;
	} tick_t;

	localparam int STALL_LIMIT  = 5000;  // cycles with no transaction on either side
	localparam int HOLDOFF_LEN  = 400;   // long output hold-off, fills the block
	localparam int RANDOM_TICKS = 150;   // per random phase
	localparam int PHASES       = 12;
	localparam int PHASE_PERIOD [10] = '{125, 1000, 0, 333, 125, 2000, 32767, 750, 125, 4000};

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]  cfg_wdata;

	rci_in_if  sticks_if ();
	rci_out_if ramped_if ();

	rc_command_interpolator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.sticks    (sticks_if),
		.ramped    (ramped_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// interpolator state as the block should hold it
	// ------------------------------------------------------------------
	logic                       smooth_on;
	logic [PER_W-1:0]           period_reg;
	logic signed [CMD_W-1:0]    ramp_target [CHANNELS];
	logic signed [DELTA_W-1:0]  ramp_slope  [CHANNELS];
	logic [STEP_W-1:0]          ticks_left;
	logic [STEP_W-1:0]          ramp_len;

	tick_t  tick_queue [$];   // ticks waiting for the driver
	cmds_t  ramp_expect [$];  // commands the block still owes us
	tick_t  on_wire;          // tick currently offered on the sticks channel

	int ticks_queued, ticks_sent, results_seen;
	int frames_seen, ramp_ticks, cfg_writes, errors;
	int holdoff_left;
	logic [$clog2(STALL_LIMIT+1):0] stall_cycles;

	string chan_name [CHANNELS] = '{"roll", "pitch", "yaw", "throttle"};

	function automatic int clip(input int v, input int lo, input int hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// point on the ramp k steps short of its target; quotient truncates toward zero
	function automatic int ramp_point(input int target, input int slope, input int k, input int n);
		int d;
		d = (n == 0) ? 1 : n;
		return target - (slope * k) / d;
	endfunction

	// advance the ramp state by one tick and give the commands the block must emit
	task automatic predict_tick(input tick_t t, output cmds_t res);
		int c, iv, per, n, now, cmdv;
		res = t.cmd;
		if (smooth_on) begin
			if (t.new_frame) begin
				iv  = clip(int'(t.interval), IV_MIN, IV_MAX) + IV_ADD;
				per = clip(int'(period_reg), PER_MIN, PER_MAX);
				n   = (iv / per + 1) & 8'hFF;
				for (c = 0; c < CHANNELS; c++) begin
					cmdv = int'($signed(t.cmd[c]));
					// where the old ramp stands, seen through the new ramp length
					now  = ramp_point(int'(ramp_target[c]), int'(ramp_slope[c]),
					                  int'(ticks_left), n);
					ramp_slope[c]  = DELTA_W'(clip(cmdv - now, DELTA_MIN, DELTA_MAX));
					ramp_target[c] = CMD_W'(cmdv);
				end
				ramp_len   = STEP_W'(n);
				ticks_left = (n == 0) ? '0 : STEP_W'(n - 1);
				frames_seen++;
			end else if (ticks_left > 0) begin
				ticks_left = ticks_left - 1'b1;
			end
			if (ticks_left > 0) begin
				ramp_ticks++;
				for (c = 0; c < CHANNELS; c++) begin
					res[c] = CMD_W'(clip(ramp_point(int'(ramp_target[c]), int'(ramp_slope[c]),
					                                int'(ticks_left), int'(ramp_len)),
					                     CMD_MIN, CMD_MAX));
				end
			end
		end
	endtask

	task automatic flag_error(input string msg);
		errors++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	function automatic tick_t mk_tick(input logic nf, input int iv,
	                                  input int r, input int p, input int y, input int th);
		tick_t t;
		t.new_frame = nf;
		t.interval  = IV_W'(iv);
		t.cmd[0]    = CMD_W'(r);
		t.cmd[1]    = CMD_W'(p);
		t.cmd[2]    = CMD_W'(y);
		t.cmd[3]    = CMD_W'(th);
		return t;
	endfunction

	function automatic void enqueue(input tick_t t);
		tick_queue.push_back(t);
		ticks_queued++;
	endfunction

	// register write while the block is idle; predictor follows the same write
	task automatic write_reg(input logic [IDX_W-1:0] idx, input int val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_W'(val);
		if (idx == REG_SMOOTH) begin
			smooth_on = val[0];
		end else begin
			period_reg = PER_W'(val);
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_writes++;
	endtask

	// every queued tick taken and every owed result seen
	task automatic wait_drained();
		do @(posedge clk); while (ticks_sent != ticks_queued || ramp_expect.size() != 0);
	endtask

	// mostly well-formed receiver traffic: frames spaced about one ramp apart,
	// sticks sliding around with the odd jump to a rail; some pure noise ticks
	task automatic queue_random(input int count, input int per);
		int i, c, v, iv, est, frame_wait;
		tick_t t;
		cmds_t stick;
		stick = cmds_t'({$urandom, $urandom});
		frame_wait = 0;
		for (i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				t.new_frame = 1'($urandom_range(0, 1));
				t.interval  = IV_W'($urandom_range(0, 65535));
				t.cmd       = cmds_t'({$urandom, $urandom});
			end else begin
				for (c = 0; c < CHANNELS; c++) begin
					if ($urandom_range(0, 7) == 0) begin
						case ($urandom_range(0, 3))
							0: stick[c] = CMD_W'(CMD_MAX);
							1: stick[c] = CMD_W'(CMD_MIN);
							default: stick[c] = CMD_W'($urandom);
						endcase
					end else begin
						v = int'($signed(stick[c])) + int'($urandom_range(0, 400)) - 200;
						stick[c] = CMD_W'(clip(v, CMD_MIN, CMD_MAX));
					end
				end
				t.cmd       = stick;
				t.new_frame = (frame_wait == 0);
				t.interval  = IV_W'($urandom_range(0, 65535));
				if (t.new_frame) begin
					case ($urandom_range(0, 9))
						0: iv = $urandom_range(0, 65535);
						1: iv = $urandom_range(0, IV_MIN);
						2: iv = $urandom_range(IV_MAX, 24000);
						default: iv = $urandom_range(IV_MIN, IV_MAX);
					endcase
					t.interval = IV_W'(iv);
					// next frame lands near the end of this ramp, sometimes well inside it
					est = (clip(iv, IV_MIN, IV_MAX) + IV_ADD) / clip(per, PER_MIN, PER_MAX) + 1;
					frame_wait = $urandom_range(0, est + 1);
				end else begin
					frame_wait--;
				end
			end
			enqueue(t);
		end
	endtask

	// ------------------------------------------------------------------
	// driver: offers queued ticks, predicts each one at its transaction
	// ------------------------------------------------------------------
	always @(posedge clk) begin : drive_sticks
		cmds_t want;
		logic  offer;
		logic  in_quiet;
		if (!arst_n) begin
			sticks_if.valid <= 1'b0;
		end else begin
			offer    = sticks_if.valid;
			in_quiet = (ticks_sent >= 600 && ticks_sent < 1000);
			if (sticks_if.valid && sticks_if.ready) begin
				predict_tick(on_wire, want);
				ramp_expect.push_back(want);
				ticks_sent++;
				offer = 1'b0;
			end
			// idle about 8 percent of the time, never inside the quiet window
			if (!offer && tick_queue.size() > 0 && (in_quiet || $urandom_range(0, 99) >= 8)) begin
				on_wire = tick_queue.pop_front();
				sticks_if.new_frame      <= on_wire.new_frame;
				sticks_if.rx_interval_us <= on_wire.interval;
				sticks_if.cmd_roll       <= on_wire.cmd[0];
				sticks_if.cmd_pitch      <= on_wire.cmd[1];
				sticks_if.cmd_yaw        <= on_wire.cmd[2];
				sticks_if.cmd_throttle   <= on_wire.cmd[3];
				offer = 1'b1;
			end
			sticks_if.valid <= offer;
		end
	end

	// ------------------------------------------------------------------
	// monitor: checks each result transaction, drives ready with stalls
	// ------------------------------------------------------------------
	always @(posedge clk) begin : watch_ramped
		cmds_t got, want;
		logic  rdy;
		int    c;
		if (!arst_n) begin
			ramped_if.ready <= 1'b0;
		end else begin
			if (ramped_if.valid && ramped_if.ready) begin
				got = {ramped_if.out_throttle, ramped_if.out_yaw,
				       ramped_if.out_pitch, ramped_if.out_roll};
				if (ramp_expect.size() == 0) begin
					flag_error($sformatf("result with nothing pending: %0d %0d %0d %0d",
					                     $signed(got[0]), $signed(got[1]),
					                     $signed(got[2]), $signed(got[3])));
				end else begin
					want = ramp_expect.pop_front();
					for (c = 0; c < CHANNELS; c++) begin
						if (got[c] !== want[c]) begin
							flag_error($sformatf("result %0d %s: got %0d, want %0d", results_seen,
							                     chan_name[c], $signed(got[c]), $signed(want[c])));
						end
					end
				end
				results_seen++;
				// hold the output back long enough for the input side to back up
				if (results_seen == 250 || results_seen == 1400) begin
					holdoff_left = HOLDOFF_LEN;
				end
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				rdy = 1'b0;
			end else begin
				rdy = (results_seen >= 650 && results_seen < 1050) || $urandom_range(0, 99) >= 8;
			end
			ramped_if.ready <= rdy;
		end
	end

	// ------------------------------------------------------------------
	// watchdog: no transaction on either channel for too long
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || (sticks_if.valid && sticks_if.ready) ||
		    (ramped_if.valid && ramped_if.ready)) begin
			stall_cycles <= '0;
		end else begin
			stall_cycles <= stall_cycles + 1'b1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout: %0d ticks sent, %0d results seen, %0d owed",
			         ticks_sent, results_seen, ramp_expect.size());
			$display("rc_command_interpolator_tb NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// sequence: reset, directed ticks, then random phases
	// ------------------------------------------------------------------
	initial begin : run_sequence
		int p, per;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		sticks_if.valid          = 1'b0;
		sticks_if.new_frame      = 1'b0;
		sticks_if.rx_interval_us = '0;
		sticks_if.cmd_roll       = '0;
		sticks_if.cmd_pitch      = '0;
		sticks_if.cmd_yaw        = '0;
		sticks_if.cmd_throttle   = '0;
		ramped_if.ready          = 1'b0;

		// predictor at reset
		smooth_on  = 1'b0;
		period_reg = PER_W'(PER_RESET);
		for (p = 0; p < CHANNELS; p++) begin
			ramp_target[p] = '0;
			ramp_slope[p]  = '0;
		end
		ticks_left   = '0;
		ramp_len     = '0;
		holdoff_left = 0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// smoothing off after reset: straight pass-through, frames ignored
		enqueue(mk_tick(1'b1, 65535, CMD_MAX, CMD_MIN, 0, -1));
		enqueue(mk_tick(1'b0, 0, CMD_MIN, CMD_MAX, -1, 0));
		enqueue(mk_tick(1'b1, 1000, 1365, -1366, CMD_MAX, CMD_MIN));
		wait_drained();

		// smoothing on, reset period; first tick has no ramp length yet
		write_reg(REG_SMOOTH, 1);
		enqueue(mk_tick(1'b0, 0, 100, 200, 300, 400));
		// interval below the floor: short three-step ramp to the rails
		enqueue(mk_tick(1'b1, 0, CMD_MAX, CMD_MIN, CMD_MAX, CMD_MIN));
		enqueue(mk_tick(1'b0, 0, CMD_MAX, CMD_MIN, CMD_MAX, CMD_MIN));
		enqueue(mk_tick(1'b0, 0, CMD_MAX, CMD_MIN, CMD_MAX, CMD_MIN));
		// ramp done, count must stay at zero
		enqueue(mk_tick(1'b0, 0, CMD_MAX, CMD_MIN, CMD_MAX, CMD_MIN));
		wait_drained();

		// fastest loop: longest ramp, then a short frame cutting into it,
		// which drives the ramp delta and the outputs into saturation
		write_reg(REG_PERIOD, PER_MIN);
		enqueue(mk_tick(1'b1, 65535, CMD_MIN, CMD_MAX, CMD_MIN, CMD_MAX));
		enqueue(mk_tick(1'b0, 0, CMD_MIN, CMD_MAX, CMD_MIN, CMD_MAX));
		enqueue(mk_tick(1'b0, 0, CMD_MIN, CMD_MAX, CMD_MIN, CMD_MAX));
		enqueue(mk_tick(1'b0, 0, CMD_MIN, CMD_MAX, CMD_MIN, CMD_MAX));
		enqueue(mk_tick(1'b1, IV_MIN, CMD_MAX, CMD_MIN, CMD_MAX, CMD_MIN));
		enqueue(mk_tick(1'b0, 0, CMD_MAX, CMD_MIN, CMD_MAX, CMD_MIN));
		enqueue(mk_tick(1'b1, IV_MAX, 0, 0, 0, 0));
		wait_drained();

		// smoothing off mid-ramp: pass-through, ramp state must be held
		write_reg(REG_SMOOTH, 0);
		enqueue(mk_tick(1'b1, 3000, 5, -5, 5, -5));
		wait_drained();
		write_reg(REG_SMOOTH, 1);
		enqueue(mk_tick(1'b0, 0, 0, 0, 0, 0));
		enqueue(mk_tick(1'b0, 0, 0, 0, 0, 0));
		wait_drained();

		// period of zero saturates up to the minimum divisor
		write_reg(REG_PERIOD, 0);
		enqueue(mk_tick(1'b1, IV_MAX - 1, -700, 700, 1, -1));
		enqueue(mk_tick(1'b0, 0, -700, 700, 1, -1));
		wait_drained();

		// period above the maximum: one-step ramps, output equals command
		write_reg(REG_PERIOD, 32767);
		enqueue(mk_tick(1'b1, IV_MAX, 1000, -1000, 2000, -2000));
		enqueue(mk_tick(1'b0, 0, 1000, -1000, 2000, -2000));
		wait_drained();

		// random phases, each with its own setting, written while idle
		for (p = 0; p < PHASES; p++) begin
			per = (p < 10) ? PHASE_PERIOD[p] : $urandom_range(0, 32767);
			write_reg(REG_SMOOTH, ($urandom_range(0, 4) != 0) ? 1 : 0);
			write_reg(REG_PERIOD, per);
			queue_random(RANDOM_TICKS, per);
			wait_drained();
		end

		// catch anything the block emits late
		repeat (300) @(posedge clk);

		$display("%0d ticks (%0d new frames, %0d mid-ramp outputs), %0d results checked",
		         ticks_sent, frames_seen, ramp_ticks, results_seen);
		$display("%0d register writes, %0d errors", cfg_writes, errors);
		if (errors == 0) begin
			$display("rc_command_interpolator_tb OK");
		end else begin
			$display("rc_command_interpolator_tb NOT OK");
		end
		$finish;
	end

endmodule

>>> rc_command_interpolator.f
rtl/core/rci_pkg.sv
rtl/core/rci_if.sv
rtl/core/rci_divider.sv
rtl/core/rci_sequencer.sv
rtl/core/rc_command_interpolator.sv
tb/sv/rc_command_interpolator_tb.sv
